// ===== src/itra_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package itra_pkg;

	// width of the value field on the request channel
	localparam int unsigned VALUE_W = 64;
	localparam int unsigned RADIX_W = 6;
	localparam int unsigned CHAR_W = 7;

	// default word width handed to the core
	localparam int unsigned WORD_WIDTH_DEF = 64;

	// valid base range
	localparam int unsigned RADIX_MIN = 2;
	localparam int unsigned RADIX_MAX = 36;

	// ascii offsets for numeric and alphabetic digits
	localparam int unsigned ASCII_ZERO = 48;
	localparam int unsigned ASCII_ALPHA_BASE = 55;
	localparam int unsigned DEC_DIGITS = 10;

	// request beat
	typedef struct packed {
		logic [VALUE_W-1:0] value_bits;
		logic [RADIX_W-1:0] radix;
		logic               func;
	} req_beat_t;

	// response beat
	typedef struct packed {
		logic [CHAR_W-1:0] digit_char;
		logic              minus_before;
		logic              last;
		logic              error;
	} rsp_beat_t;

	// digit value to ascii character
	function automatic logic [CHAR_W-1:0] digit_ascii(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] d_ext;
		d_ext = {{(CHAR_W-RADIX_W){1'b0}}, d};
		if (d < RADIX_W'(DEC_DIGITS)) begin
			digit_ascii = d_ext + CHAR_W'(ASCII_ZERO);
		end else begin
			digit_ascii = d_ext + CHAR_W'(ASCII_ALPHA_BASE);
		end
	endfunction

endpackage

`default_nettype wire

// ===== src/integer_to_radix_ascii_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Converts one WORD_WIDTH-bit word into the ASCII digits of its value in base 2..36,
// most significant digit first, one response beat per digit. In signed mode
// (func = 0) a negative word is sent as its magnitude with minus_before set on the
// first digit; zero gives a single '0'; a base outside 2..36 gives one error beat.
// Digits are produced by a single restoring divider that retires one quotient bit
// per cycle; the digits are kept in a small digit memory and replayed in reverse,
// each digit passing a fetch state and an emit state. req_stall stays high for the
// whole conversion and drops once the last beat sits in the output register, so
// the next request can be taken while that beat still waits.
module integer_to_radix_ascii_core
	import itra_pkg::*;
#(
	parameter int unsigned WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        req_valid,
	output logic       req_stall,
	input  req_beat_t  req_beat,
	output logic       rsp_valid,
	input  wire        rsp_stall,
	output rsp_beat_t  rsp_beat
);

	localparam int unsigned IDX_W = $clog2(WORD_WIDTH);
	localparam int unsigned CNT_W = $clog2(WORD_WIDTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SINGLE,
		S_DIVIDE,
		S_STORE,
		S_FETCH,
		S_EMIT
	} state_t;

	state_t                 state_q;
	logic                   rsp_valid_q;
	rsp_beat_t              rsp_beat_q;
	rsp_beat_t              single_q;
	logic [WORD_WIDTH-1:0]  work_q;
	logic [RADIX_W-1:0]     rem_q;
	logic [RADIX_W-1:0]     radix_q;
	logic [IDX_W-1:0]       bit_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   neg_q;
	logic                   first_q;
	logic [RADIX_W-1:0]     rd_q;

	logic [RADIX_W-1:0]     dig_mem [WORD_WIDTH];

	logic [WORD_WIDTH-1:0]  word_in;
	logic                   neg_in;
	logic [WORD_WIDTH-1:0]  mag_in;
	logic                   radix_ok;
	logic [RADIX_W:0]       trial;
	logic [RADIX_W:0]       diff;
	logic                   ge;
	logic                   slot_free;
	logic                   beat_load;
	logic [CNT_W-1:0]       cnt_m1;

	// request decode: magnitude and base check
	assign word_in  = req_beat.value_bits[WORD_WIDTH-1:0];
	assign neg_in   = !req_beat.func && word_in[WORD_WIDTH-1];
	assign mag_in   = neg_in ? (~word_in + 1'b1) : word_in;
	assign radix_ok = (req_beat.radix >= RADIX_W'(RADIX_MIN)) &&
		(req_beat.radix <= RADIX_W'(RADIX_MAX));

	// shared restoring divider step
	assign trial = {rem_q, work_q[WORD_WIDTH-1]};
	assign diff  = trial - {1'b0, radix_q};
	assign ge    = (trial >= {1'b0, radix_q});

	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign beat_load = slot_free && ((state_q == S_SINGLE) || (state_q == S_EMIT));
	assign cnt_m1    = cnt_q - 1'b1;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_beat  = rsp_beat_q;

	// digit memory write
	always_ff @(posedge clk) begin
		if (state_q == S_STORE) begin
			dig_mem[cnt_q[IDX_W-1:0]] <= rem_q;
		end
	end

	// digit memory read, registered
	always_ff @(posedge clk) begin
		rd_q <= dig_mem[cnt_m1[IDX_W-1:0]];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			cnt_q       <= '0;
			bit_q       <= '0;
			neg_q       <= 1'b0;
			first_q     <= 1'b0;
		end else begin
			// output register: load a new beat or retire the accepted one
			if (beat_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						radix_q <= req_beat.radix;
						neg_q   <= neg_in;
						first_q <= 1'b1;
						work_q  <= mag_in;
						rem_q   <= '0;
						bit_q   <= '0;
						cnt_q   <= '0;
						if (!radix_ok) begin
							single_q <= '{digit_char: '0, minus_before: 1'b0,
								last: 1'b1, error: 1'b1};
							state_q  <= S_SINGLE;
						end else if (mag_in == '0) begin
							single_q <= '{digit_char: CHAR_W'(ASCII_ZERO),
								minus_before: 1'b0, last: 1'b1, error: 1'b0};
							state_q  <= S_SINGLE;
						end else begin
							state_q <= S_DIVIDE;
						end
					end
				end
				S_SINGLE: begin
					if (slot_free) begin
						rsp_beat_q  <= single_q;
						state_q     <= S_IDLE;
					end
				end
				S_DIVIDE: begin
					// one quotient bit per cycle
					work_q <= {work_q[WORD_WIDTH-2:0], ge};
					rem_q  <= ge ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
					bit_q  <= bit_q + 1'b1;
					if (bit_q == IDX_W'(WORD_WIDTH - 1)) begin
						state_q <= S_STORE;
					end
				end
				S_STORE: begin
					// remainder goes to memory, quotient divides again
					cnt_q <= cnt_q + 1'b1;
					bit_q <= '0;
					rem_q <= '0;
					if (work_q == '0) begin
						state_q <= S_FETCH;
					end else begin
						state_q <= S_DIVIDE;
					end
				end
				S_FETCH: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					// replay digits from the top of memory
					if (slot_free) begin
						rsp_beat_q  <= '{digit_char: digit_ascii(rd_q),
							minus_before: neg_q && first_q,
							last: (cnt_q == CNT_W'(1)), error: 1'b0};
						first_q     <= 1'b0;
						cnt_q       <= cnt_m1;
						if (cnt_q == CNT_W'(1)) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_FETCH;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// an error beat always closes its conversion
	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_beat.error |-> rsp_beat.last)
		else $error("error beat without last");

	// sign flag never rides on an error beat
	a_minus_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_beat.minus_before |-> !rsp_beat.error)
		else $error("minus flag on error beat");

	// divider remainder stays below the base
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIVIDE |-> rem_q < radix_q)
		else $error("divider remainder out of range");

	// an accepted request starts a conversion
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> state_q != S_IDLE)
		else $error("request accepted but sequencer idle");

	// digit count never exceeds the word width
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(WORD_WIDTH))
		else $error("digit count overflow");

endmodule

`default_nettype wire

// ===== tb/sv/integer_to_radix_ascii_core_test.sv =====
`timescale 1ns / 1ps

module integer_to_radix_ascii_core_test;
	import itra_pkg::*;

	// conversion selectors carried in func
	localparam logic FUNC_SIGNED   = 1'b0;
	localparam logic FUNC_UNSIGNED = 1'b1;

	localparam int unsigned RANDOM_REQS  = 120;
	localparam int unsigned HOLD_AT_REQ  = 30;
	localparam int unsigned HOLD_CYCLES  = 6000;
	localparam int unsigned TAIL_CYCLES  = 300;
	localparam int unsigned CYCLE_LIMIT  = 8000000;

	typedef struct {
		req_beat_t   beat;
		int unsigned gap_before;
		bit          drain_first;
	} pending_req_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_beat_t req_beat = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_beat_t rsp_beat;

	pending_req_t pending_reqs[$];
	rsp_beat_t    expected_digits[$];
	int unsigned  mismatches = 0;
	int unsigned  cycle_count = 0;

	// driver state
	logic        offer;
	int unsigned idle_count = 0;

	// receiver state
	logic        stall_next;
	int unsigned reqs_seen = 0;
	int unsigned hold_left = 0;
	int unsigned stall_left = 0;
	int unsigned free_left = 0;

	integer_to_radix_ascii_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_beat  (req_beat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_beat  (rsp_beat)
	);

	// idle length: mostly none or short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 80);
	endfunction

	// digit beats for one request, most significant digit first
	function automatic void predict_digits(input req_beat_t b);
		logic [63:0]       mag;
		logic [63:0]       base;
		logic [63:0]       d;
		logic [CHAR_W-1:0] digs[$];
		logic              neg;
		rsp_beat_t         r;
		r = '0;
		base = 64'(b.radix);
		mag = b.value_bits;
		neg = 1'b0;
		if (b.radix < RADIX_MIN || b.radix > RADIX_MAX) begin
			r.last = 1'b1;
			r.error = 1'b1;
			expected_digits.push_back(r);
		end else if (mag == 64'd0) begin
			r.digit_char = CHAR_W'(ASCII_ZERO);
			r.last = 1'b1;
			expected_digits.push_back(r);
		end else begin
			// signed negative words go out as magnitude plus minus flag
			if (b.func == FUNC_SIGNED && mag[63]) begin
				neg = 1'b1;
				mag = -mag;
			end
			while (mag != 64'd0) begin
				d = mag % base;
				if (d < DEC_DIGITS) begin
					digs.push_front(CHAR_W'(d + ASCII_ZERO));
				end else begin
					digs.push_front(CHAR_W'(d + ASCII_ALPHA_BASE));
				end
				mag = mag / base;
			end
			foreach (digs[k]) begin
				r.digit_char = digs[k];
				r.minus_before = (k == 0) ? neg : 1'b0;
				r.last = (k == digs.size() - 1);
				r.error = 1'b0;
				expected_digits.push_back(r);
			end
		end
	endfunction

	task automatic queue_request(input logic [63:0] value, input logic [RADIX_W-1:0] radix,
			input logic func, input int unsigned gap, input bit drain);
		pending_req_t p;
		p.beat.value_bits = value;
		p.beat.radix = radix;
		p.beat.func = func;
		p.gap_before = gap;
		p.drain_first = drain;
		pending_reqs.push_back(p);
	endtask

	task automatic check_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
			mismatches++;
		end
	endtask

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// reset, held and then released
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// cycle limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d beats still expected", $time,
				expected_digits.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// request driver: offers queued beats, honoring gaps and drain points
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_beat <= '0;
			idle_count = 0;
		end else begin
			offer = req_valid;
			if (req_valid && !req_stall) begin
				predict_digits(req_beat);
				offer = 1'b0;
			end
			if (!offer && pending_reqs.size() != 0) begin
				if (idle_count < pending_reqs[0].gap_before) begin
					idle_count++;
				end else if (!pending_reqs[0].drain_first || expected_digits.size() == 0) begin
					req_beat <= pending_reqs[0].beat;
					void'(pending_reqs.pop_front());
					idle_count = 0;
					offer = 1'b1;
				end
			end
			req_valid <= offer;
		end
	end

	// response stall: random bursts, calm stretches and one long hold
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold_left = 0;
			stall_left = 0;
			free_left = 0;
		end else begin
			if (req_valid && !req_stall) begin
				reqs_seen++;
				if (reqs_seen == HOLD_AT_REQ) begin
					hold_left = HOLD_CYCLES;
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else if (stall_left != 0) begin
				stall_left--;
				stall_next = 1'b1;
			end else if (free_left != 0) begin
				free_left--;
				stall_next = 1'b0;
			end else begin
				free_left = ($urandom_range(0, 19) == 0) ? 400 : $urandom_range(0, 8);
				stall_left = pick_gap();
				stall_next = 1'b0;
			end
			rsp_stall <= stall_next;
		end
	end

	// response monitor: each accepted beat against the oldest expected digit
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_digits.size() == 0) begin
				$display("%0t: unexpected beat, expected none actual %h", $time, rsp_beat);
				mismatches++;
			end else begin
				check_field("digit_char", 64'(expected_digits[0].digit_char),
					64'(rsp_beat.digit_char));
				check_field("minus_before", 64'(expected_digits[0].minus_before),
					64'(rsp_beat.minus_before));
				check_field("last", 64'(expected_digits[0].last), 64'(rsp_beat.last));
				check_field("error", 64'(expected_digits[0].error), 64'(rsp_beat.error));
				void'(expected_digits.pop_front());
			end
		end
	end

	// stimulus and end of run
	initial begin
		logic [63:0]        value;
		logic [RADIX_W-1:0] radix;
		int unsigned        kind;
		int unsigned        gap;

		// directed: zero, extremes, most negative, bad bases, letter digits
		queue_request(64'd0, 6'd10, FUNC_SIGNED, 0, 1'b0);
		queue_request(64'd0, 6'd2, FUNC_UNSIGNED, 0, 1'b0);
		queue_request('1, 6'd2, FUNC_UNSIGNED, 0, 1'b0);
		queue_request('1, 6'd10, FUNC_SIGNED, pick_gap(), 1'b0);
		queue_request('1, 6'd36, FUNC_UNSIGNED, pick_gap(), 1'b0);
		queue_request({1'b1, 63'd0}, 6'd10, FUNC_SIGNED, pick_gap(), 1'b0);
		queue_request({1'b1, 63'd0}, 6'd2, FUNC_SIGNED, pick_gap(), 1'b0);
		queue_request({1'b1, 63'd0}, 6'd16, FUNC_UNSIGNED, pick_gap(), 1'b0);
		queue_request({1'b0, {63{1'b1}}}, 6'd36, FUNC_SIGNED, pick_gap(), 1'b0);
		queue_request(64'd123, 6'd0, FUNC_SIGNED, pick_gap(), 1'b0);
		queue_request('1, 6'd1, FUNC_UNSIGNED, pick_gap(), 1'b0);
		queue_request(64'd0, 6'd37, FUNC_SIGNED, pick_gap(), 1'b0);
		queue_request('1, 6'd63, FUNC_UNSIGNED, pick_gap(), 1'b0);
		queue_request(64'd35, 6'd36, FUNC_UNSIGNED, pick_gap(), 1'b0);
		queue_request(64'hDEAD_BEEF, 6'd16, FUNC_SIGNED, pick_gap(), 1'b0);
		queue_request(64'd9, 6'd10, FUNC_SIGNED, pick_gap(), 1'b0);
		queue_request(64'd10, 6'd10, FUNC_UNSIGNED, pick_gap(), 1'b0);
		queue_request(64'd1, 6'd2, FUNC_SIGNED, pick_gap(), 1'b0);
		queue_request(-64'd36, 6'd36, FUNC_SIGNED, pick_gap(), 1'b0);
		queue_request(-64'd36, 6'd36, FUNC_UNSIGNED, pick_gap(), 1'b0);
		queue_request(64'h0123_4567_89AB_CDEF, 6'd3, FUNC_SIGNED, pick_gap(), 1'b0);

		// random: mostly valid bases with mixed value shapes
		for (int i = 0; i < RANDOM_REQS; i++) begin
			kind = $urandom_range(0, 7);
			case (kind)
				3: value = 64'($urandom_range(0, 1000));
				4: value = -64'($urandom_range(1, 1000));
				5: value = 64'd1 << $urandom_range(0, 63);
				6: begin
					case ($urandom_range(0, 2))
						0: value = {1'b1, 63'd0};
						1: value = '1;
						default: value = {1'b0, {63{1'b1}}};
					endcase
				end
				7: value = {32'd0, $urandom};
				default: value = {$urandom, $urandom};
			endcase
			if ($urandom_range(0, 99) < 8) begin
				radix = $urandom_range(0, 1) ? RADIX_W'($urandom_range(0, 1))
					: RADIX_W'($urandom_range(37, 63));
			end else begin
				radix = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
			end
			gap = (i >= 100 && i < 120) ? 0 : pick_gap();
			queue_request(value, radix, 1'($urandom_range(0, 1)), gap, i == 0 || i == 70);
		end

		// drain everything, then watch a while for stray beats
		@(posedge clk);
		while (!arst_n || pending_reqs.size() != 0 || req_valid || expected_digits.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ===== integer_to_radix_ascii_core.f =====
src/itra_pkg.sv
src/integer_to_radix_ascii_core.sv
tb/sv/integer_to_radix_ascii_core_test.sv
